/* hdl/mpl3_pkg.sv */
`default_nettype none

package mpl3_pkg;

    // Grid geometry
    localparam int DIM_MAX    = 16;
    localparam int POS_W      = $clog2(DIM_MAX);
    localparam int SIZE_W     = POS_W + 1;
    localparam int ADDR_W     = 3 * POS_W;
    localparam int CELLS      = DIM_MAX * DIM_MAX * DIM_MAX;

    // Number format
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int K_W        = 32;
    localparam int K_HALF     = K_W / 2;

    // Datapath widths: axis difference, partial product, accumulator, scaled sum
    localparam int D_W        = VALUE_BITS + 3;
    localparam int PROD_W     = D_W + K_HALF + 1;
    localparam int ACC_W      = D_W + K_W + 2;
    localparam int Q_W        = ACC_W - FRAC_BITS;

    localparam int MUL_STEPS  = 6;
    localparam int STEP_W     = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DIM_MAX);
    localparam logic [K_W-1:0]    K_RESET    = K_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_INV_X  = 3'd3,
        CFG_INV_Y  = 3'd4,
        CFG_INV_Z  = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_code_t;

    // Order of the seven grid reads for one evaluation
    typedef enum logic [STEP_W-1:0] {
        RD_C  = 3'd0,
        RD_XE = 3'd1,
        RD_XW = 3'd2,
        RD_YE = 3'd3,
        RD_YW = 3'd4,
        RD_ZE = 3'd5,
        RD_ZW = 3'd6
    } rd_step_t;

    localparam int RD_STEPS = 7;

    typedef struct packed {
        logic                 load;
        logic                 latch;
        logic                 rd_en;
        rd_step_t             rd_sel;
        logic                 mul_en;
        logic [STEP_W-1:0]    mul_sel;
        logic                 fin;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* hdl/mpl3_ctrl.sv */
`default_nettype none

module mpl3_ctrl
    import mpl3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    command,
    output logic         busy,
    output logic         done,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_code_t'(command) == CMD_EVAL))
                begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == STEP_W'(RD_STEPS - 1))
                begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_ACC;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_ACC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd.load    = accept && (cmd_code_t'(command) == CMD_LOAD);
        cmd.latch   = accept && (cmd_code_t'(command) == CMD_EVAL);
        cmd.rd_en   = (state_reg == ST_READ);
        cmd.rd_sel  = rd_step_t'(cnt_reg);
        cmd.mul_en  = (state_reg == ST_MUL);
        cmd.mul_sel = cnt_reg;
        cmd.fin     = (state_reg == ST_FIN);
    end

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // An accepted evaluation makes the block busy next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command) |=> busy)
        else $error("evaluation accepted but block not busy");

    // Reads and multiplies never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.mul_en))
        else $error("read and multiply issued together");

    // A result follows only the finish step
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.fin))
        else $error("result strobe without finish step");

endmodule

`default_nettype wire

/* hdl/mpl3_dpath.sv */
`default_nettype none

module mpl3_dpath
    import mpl3_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dp_cmd_t                      cmd,
    input  wire logic [POS_W-1:0]             pos_x,
    input  wire logic [POS_W-1:0]             pos_y,
    input  wire logic [POS_W-1:0]             pos_z,
    input  wire logic signed [VALUE_BITS-1:0] sample_value,
    input  wire logic                         in_domain,
    input  wire logic [SIZE_W-1:0]            size_x,
    input  wire logic [SIZE_W-1:0]            size_y,
    input  wire logic [SIZE_W-1:0]            size_z,
    input  wire logic [K_W-1:0]               inv_step_sq_x,
    input  wire logic [K_W-1:0]               inv_step_sq_y,
    input  wire logic [K_W-1:0]               inv_step_sq_z,
    output logic signed [VALUE_BITS-1:0]      lap_value,
    output logic                              point_active,
    output logic                              saturated
);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0)
            r = SIZE_W'(1);
        else if (s > SIZE_W'(DIM_MAX))
            r = SIZE_W'(DIM_MAX);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] nbr_next(input logic [POS_W-1:0] p,
                                                  input logic [SIZE_W-1:0] n);
        logic [POS_W-1:0] r;
        r = p + POS_W'(1);
        if ((SIZE_W'(p) + SIZE_W'(1)) == n)
            r = '0;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] nbr_prev(input logic [POS_W-1:0] p,
                                                  input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] top;
        logic [POS_W-1:0]  r;
        top = n - SIZE_W'(1);
        r   = p - POS_W'(1);
        if (p == '0)
            r = top[POS_W-1:0];
        return r;
    endfunction

    // Grid memory: value with its domain mark in the top bit
    logic [VALUE_BITS:0]   mem [CELLS];
    logic [VALUE_BITS:0]   rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  cap_en_reg;
    rd_step_t              cap_sel_reg;

    logic [POS_W-1:0]      x_reg, y_reg, z_reg;
    logic [SIZE_W-1:0]     nx, ny, nz;
    logic                  range_ok;

    logic signed [VALUE_BITS-1:0] rd_val;
    logic signed [VALUE_BITS-1:0] c_reg, e_reg;
    logic                         mark_reg;
    logic signed [D_W-1:0]        d_reg [3];
    logic signed [D_W-1:0]        d_new;

    logic [1:0]                   mul_axis;
    logic [K_W-1:0]               k_sel;
    logic signed [K_HALF:0]       k_part;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         prod_hi_reg;
    logic                         acc_en_reg;
    logic signed [ACC_W-1:0]      pp_ext, pp_sh, acc_reg;

    logic signed [ACC_W-1:0]      rnd;
    logic signed [Q_W-1:0]        q;
    logic                         ovf;

    logic signed [VALUE_BITS-1:0] lap_reg;
    logic                         active_reg;
    logic                         sat_reg;

    assign nx = eff_size(size_x);
    assign ny = eff_size(size_y);
    assign nz = eff_size(size_z);

    assign range_ok = (SIZE_W'(x_reg) < nx) && (SIZE_W'(y_reg) < ny) &&
                      (SIZE_W'(z_reg) < nz);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_C:    rd_addr = {z_reg, y_reg, x_reg};
            RD_XE:   rd_addr = {z_reg, y_reg, nbr_next(x_reg, nx)};
            RD_XW:   rd_addr = {z_reg, y_reg, nbr_prev(x_reg, nx)};
            RD_YE:   rd_addr = {z_reg, nbr_next(y_reg, ny), x_reg};
            RD_YW:   rd_addr = {z_reg, nbr_prev(y_reg, ny), x_reg};
            RD_ZE:   rd_addr = {nbr_next(z_reg, nz), y_reg, x_reg};
            RD_ZW:   rd_addr = {nbr_prev(z_reg, nz), y_reg, x_reg};
            default: rd_addr = {z_reg, y_reg, x_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[{pos_z, pos_y, pos_x}] <= {in_domain, sample_value};
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_en_reg  <= 1'b0;
            cap_sel_reg <= RD_C;
            acc_en_reg  <= 1'b0;
        end
        else
        begin
            cap_en_reg  <= cmd.rd_en;
            cap_sel_reg <= cmd.rd_sel;
            acc_en_reg  <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            z_reg <= pos_z;
        end
    end

    // Capture reads; fold each neighbour pair into next + previous - 2*centre
    assign rd_val = rd_data_reg[VALUE_BITS-1:0];
    assign d_new  = D_W'(e_reg) + D_W'(rd_val) - (D_W'(c_reg) <<< 1);

    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            case (cap_sel_reg)
                RD_C:
                begin
                    c_reg    <= rd_val;
                    mark_reg <= rd_data_reg[VALUE_BITS];
                end
                RD_XE, RD_YE, RD_ZE:
                begin
                    e_reg <= rd_val;
                end
                RD_XW:   d_reg[0] <= d_new;
                RD_YW:   d_reg[1] <= d_new;
                RD_ZW:   d_reg[2] <= d_new;
                default:
                begin
                    e_reg <= e_reg;
                end
            endcase
        end
    end

    // One 35x17 product per step: low then high half of each axis factor
    assign mul_axis = cmd.mul_sel[2:1];

    always_comb
    begin
        case (mul_axis)
            2'd0:    k_sel = inv_step_sq_x;
            2'd1:    k_sel = inv_step_sq_y;
            default: k_sel = inv_step_sq_z;
        endcase
        if (cmd.mul_sel[0])
            k_part = $signed({1'b0, k_sel[K_W-1:K_HALF]});
        else
            k_part = $signed({1'b0, k_sel[K_HALF-1:0]});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg    <= PROD_W'(d_reg[mul_axis] * k_part);
            prod_hi_reg <= cmd.mul_sel[0];
        end
    end

    assign pp_ext = ACC_W'(prod_reg);
    assign pp_sh  = prod_hi_reg ? (pp_ext <<< K_HALF) : pp_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            acc_reg <= '0;
        else if (acc_en_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    // Round to nearest (ties up), then clip to the value range
    assign rnd = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign q   = rnd[ACC_W-1:FRAC_BITS];
    assign ovf = !((&q[Q_W-1:VALUE_BITS-1]) || !(|q[Q_W-1:VALUE_BITS-1]));

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            active_reg <= range_ok && mark_reg;
            if (!(range_ok && mark_reg))
            begin
                lap_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (ovf)
            begin
                lap_reg <= q[Q_W-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                    : {1'b0, {(VALUE_BITS-1){1'b1}}};
                sat_reg <= 1'b1;
            end
            else
            begin
                lap_reg <= q[VALUE_BITS-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign lap_value    = lap_reg;
    assign point_active = active_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

/* hdl/masked_periodic_laplacian_3d.sv */
// Masked periodic seven-point Laplacian on a 16x16x16 grid, signed Q16.16.
//
// Command channel: a command is transferred at a rising edge where start is
// high and busy is low. command = 0 loads sample_value and in_domain at
// (pos_x,pos_y,pos_z); busy stays low during a load, and loads may follow
// every cycle. command = 1 evaluates the Laplacian at a point.
// An evaluation raises busy while it runs: seven single-port grid reads (one
// per cycle), six 35x17 partial products through one multiplier, one
// accumulate and one round/clip step. The result then appears for one cycle
// with done high, and the next command is taken in that same cycle, so a new
// evaluation cannot start before the last result has appeared.
// Results cannot be held off: the receiver must take them when done is high.
// Points outside the configured sizes or whose mark is clear return zero
// with point_active and saturated low.
// Configuration: cfg_data is written to register cfg_index on a transfer with
// cfg_valid and cfg_ready high; cfg_ready is high while idle.
// Reset: sizes return to 16 and all inverse squared spacings to 1.0; the grid
// memory is not cleared and must be loaded before a point is read.
`default_nettype none

module masked_periodic_laplacian_3d
    import mpl3_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         command,
    input  wire logic [POS_W-1:0]             pos_x,
    input  wire logic [POS_W-1:0]             pos_y,
    input  wire logic [POS_W-1:0]             pos_z,
    input  wire logic signed [VALUE_BITS-1:0] sample_value,
    input  wire logic                         in_domain,
    output logic                              done,
    output logic signed [VALUE_BITS-1:0]      lap_value,
    output logic                              point_active,
    output logic                              saturated,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [K_W-1:0]               cfg_data
);

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [K_W-1:0]    inv_x_reg, inv_y_reg, inv_z_reg;
    logic              cfg_write;
    dp_cmd_t           cmd;

    // Take configuration only while no evaluation is running
    assign cfg_ready = !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
            inv_x_reg  <= K_RESET;
            inv_y_reg  <= K_RESET;
            inv_z_reg  <= K_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: size_y_reg <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: size_z_reg <= cfg_data[SIZE_W-1:0];
                CFG_INV_X:  inv_x_reg  <= cfg_data;
                CFG_INV_Y:  inv_y_reg  <= cfg_data;
                CFG_INV_Z:  inv_z_reg  <= cfg_data;
                default:
                begin
                    // drop writes to unused indexes
                    inv_x_reg <= inv_x_reg;
                end
            endcase
        end
    end

    // Sequencer: owns the handshake and steps the datapath
    mpl3_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd)
    );

    // Grid memory, neighbour addressing, multiply-accumulate and clip
    mpl3_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .sample_value  (sample_value),
        .in_domain     (in_domain),
        .size_x        (size_x_reg),
        .size_y        (size_y_reg),
        .size_z        (size_z_reg),
        .inv_step_sq_x (inv_x_reg),
        .inv_step_sq_y (inv_y_reg),
        .inv_step_sq_z (inv_z_reg),
        .lap_value     (lap_value),
        .point_active  (point_active),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire
